### rtl/core/vls_pkg.sv
package vls_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned ScaleSh  = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OutDataW = 80;

  localparam logic [ByteW-1:0] FadeOff = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_X_SCALE  = 3'd0,
    REG_Y_SCALE  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_FADE     = 3'd4,
    REG_INVERSE  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_LIST  = 2'd0,
    PH_POINT = 2'd1,
    PH_X     = 2'd2,
    PH_Y     = 2'd3
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0]  x_scale;
    logic [ByteW-1:0]  y_scale;
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic [ByteW-1:0]  fade_pattern;
    logic              inverse_mode;
  } cfg_t;

  typedef struct packed {
    logic              draw_inverse;
    logic [ByteW-1:0]  dot_mask;
    logic [CoordW-1:0] end_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] start_x;
  } seg_t;

endpackage

### rtl/core/vls_cfg.sv
module vls_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [vls_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [vls_pkg::CfgDataW-1:0]  cfg_data,
  output vls_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vls_pkg::REG_X_SCALE:  cfg.x_scale      <= cfg_data[vls_pkg::ByteW-1:0];
        vls_pkg::REG_Y_SCALE:  cfg.y_scale      <= cfg_data[vls_pkg::ByteW-1:0];
        vls_pkg::REG_CENTER_X: cfg.center_x     <= cfg_data[vls_pkg::CoordW-1:0];
        vls_pkg::REG_CENTER_Y: cfg.center_y     <= cfg_data[vls_pkg::CoordW-1:0];
        vls_pkg::REG_FADE:     cfg.fade_pattern <= cfg_data[vls_pkg::ByteW-1:0];
        vls_pkg::REG_INVERSE:  cfg.inverse_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/vls_scale.sv
module vls_scale (
  input  logic [vls_pkg::ByteW-1:0]  coord,
  input  logic [vls_pkg::ByteW-1:0]  scale,
  input  logic [vls_pkg::CoordW-1:0] centre,
  output logic [vls_pkg::CoordW-1:0] result
);

  logic signed [vls_pkg::ByteW-1:0]  delta;
  logic signed [vls_pkg::ByteW:0]    scale_s;
  logic signed [vls_pkg::CoordW:0]   prod_w;
  logic signed [vls_pkg::CoordW-1:0] prod;
  logic signed [vls_pkg::CoordW-1:0] shifted;

  // |delta| * scale <= 128 * 255, so the signed product fits in 16 bits
  always_comb begin
    delta   = $signed(coord - centre[vls_pkg::ByteW-1:0]);
    scale_s = $signed({1'b0, scale});
    prod_w  = delta * scale_s;
    prod    = prod_w[vls_pkg::CoordW-1:0];
    shifted = prod >>> vls_pkg::ScaleSh;
    result  = centre + shifted;
  end

endmodule

### rtl/core/vls_parse.sv
module vls_parse (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [vls_pkg::ByteW-1:0]  list_byte,
  input  vls_pkg::cfg_t              cfg,
  output logic                       emit,
  output vls_pkg::seg_t              seg
);

  vls_pkg::phase_t             phase, phase_next;
  logic [vls_pkg::ByteW-1:0]   lists_left, lists_left_next;
  logic [vls_pkg::ByteW-1:0]   points_left, points_left_next;
  logic [vls_pkg::CoordW-1:0]  pending_x, pending_x_next;
  logic [vls_pkg::CoordW-1:0]  previous_x, previous_x_next;
  logic [vls_pkg::CoordW-1:0]  previous_y, previous_y_next;
  logic                        have_previous, have_previous_next;

  logic [vls_pkg::ByteW-1:0]   scale_sel;
  logic [vls_pkg::CoordW-1:0]  centre_sel;
  logic [vls_pkg::CoordW-1:0]  scaled;
  logic [vls_pkg::ByteW-1:0]   lists_dec;
  logic [vls_pkg::ByteW-1:0]   points_dec;

  // one shared scaler: x and y bytes never arrive together
  assign scale_sel  = (phase == vls_pkg::PH_Y) ? cfg.y_scale  : cfg.x_scale;
  assign centre_sel = (phase == vls_pkg::PH_Y) ? cfg.center_y : cfg.center_x;

  vls_scale u_scale (
    .coord  (list_byte),
    .scale  (scale_sel),
    .centre (centre_sel),
    .result (scaled)
  );

  assign lists_dec  = lists_left - 8'd1;
  assign points_dec = points_left - 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= vls_pkg::PH_LIST;
      lists_left    <= '0;
      points_left   <= '0;
      pending_x     <= '0;
      previous_x    <= '0;
      previous_y    <= '0;
      have_previous <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      lists_left    <= lists_left_next;
      points_left   <= points_left_next;
      pending_x     <= pending_x_next;
      previous_x    <= previous_x_next;
      previous_y    <= previous_y_next;
      have_previous <= have_previous_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    lists_left_next    = lists_left;
    points_left_next   = points_left;
    pending_x_next     = pending_x;
    previous_x_next    = previous_x;
    previous_y_next    = previous_y;
    have_previous_next = have_previous;
    emit               = 1'b0;

    seg.start_x      = previous_x;
    seg.start_y      = previous_y;
    seg.end_x        = pending_x;
    seg.end_y        = scaled;
    seg.dot_mask     = cfg.fade_pattern;
    seg.draw_inverse = cfg.inverse_mode;

    unique case (phase)
      vls_pkg::PH_LIST: begin
        lists_left_next = list_byte;
        phase_next = (list_byte == '0) ? vls_pkg::PH_LIST : vls_pkg::PH_POINT;
      end
      vls_pkg::PH_POINT: begin
        points_left_next   = list_byte;
        have_previous_next = 1'b0;
        if (list_byte == '0) begin
          lists_left_next = lists_dec;
          phase_next = (lists_dec == '0) ? vls_pkg::PH_LIST : vls_pkg::PH_POINT;
        end else begin
          phase_next = vls_pkg::PH_X;
        end
      end
      vls_pkg::PH_X: begin
        pending_x_next = scaled;
        phase_next     = vls_pkg::PH_Y;
      end
      vls_pkg::PH_Y: begin
        emit               = have_previous && (cfg.fade_pattern != vls_pkg::FadeOff);
        previous_x_next    = pending_x;
        previous_y_next    = scaled;
        have_previous_next = 1'b1;
        points_left_next   = points_dec;
        if (points_dec == '0) begin
          lists_left_next = lists_dec;
          phase_next = (lists_dec == '0) ? vls_pkg::PH_LIST : vls_pkg::PH_POINT;
        end else begin
          phase_next = vls_pkg::PH_X;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/vector_list_scaler.sv
// Vector display list parser and scaler.
// s_axis: one display list byte per beat (list count, point counts, x,y
// pairs). m_axis: one line segment per beat for each consecutive point
// pair of a polyline, unless the fade pattern is 255.
// cfg: write enable, register index and data; index 0 x_scale, 1 y_scale,
// 2 center_x, 3 center_y, 4 fade_pattern, 5 inverse_mode; others ignored.
// Write registers only while no beats are in flight.
// An accepted byte is held in the input register; a segment it completes
// is registered in the output register and offered from there.
// Throughput: one byte per cycle; the scale multiply, shift, centre add
// and parser update all sit between the input and output registers.
// When m_tready is low and a segment waits, the stage holds only if it
// also has a segment to deliver; bytes that give no segment keep flowing.
// Reset zeroes config, valids and parser state, so a list count is next.
module vector_list_scaler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] list_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [15:0] start_x, [31:16] start_y, [47:32] end_x, [63:48] end_y,
  // [71:64] dot_mask, [72] draw_inverse, [79:73] zero
  output logic [vls_pkg::OutDataW-1:0]  m_tdata,
  input  logic                          cfg_we,
  input  logic [vls_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [vls_pkg::CfgDataW-1:0]  cfg_data
);

  localparam int unsigned SegW = $bits(vls_pkg::seg_t);

  vls_pkg::cfg_t               cfg;
  vls_pkg::seg_t               seg;
  logic                        in_valid;
  logic [vls_pkg::ByteW-1:0]   in_byte;
  logic                        emit;
  logic                        advance;
  logic                        out_free;

  vls_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vls_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .list_byte (in_byte),
    .cfg       (cfg),
    .emit      (emit),
    .seg       (seg)
  );

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!emit || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && emit) begin
      m_tdata <= {{(vls_pkg::OutDataW - SegW){1'b0}}, seg};
    end
  end

endmodule

### sim/vls_segment_checker.sv
`timescale 1ns / 1ps

module vls_segment_checker
  import vls_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] list_byte
  input  logic                m_tvalid,
  input  logic                m_tready,
  // [15:0] start_x, [31:16] start_y, [47:32] end_x, [63:48] end_y,
  // [71:64] dot_mask, [72] draw_inverse, [79:73] zero
  input  logic [OutDataW-1:0] m_tdata,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                run_done,
  output int unsigned         segs_pending,
  output int unsigned         fail_count
);

  localparam int unsigned SegW = $bits(seg_t);

  cfg_t              regs;
  phase_t            phase;
  logic [ByteW-1:0]  lists_left;
  logic [ByteW-1:0]  points_left;
  logic [CoordW-1:0] held_x;
  logic [CoordW-1:0] last_x;
  logic [CoordW-1:0] last_y;
  logic              have_last;
  seg_t              segs_due[$];
  int unsigned       seg_no;
  logic              leftovers_done;

  initial fail_count = 0;

  function automatic logic [CoordW-1:0] scale_about_centre(input logic [ByteW-1:0] coord,
                                                          input logic [ByteW-1:0] scale,
                                                          input logic [CoordW-1:0] centre);
    logic [ByteW-1:0]         delta;
    logic [ByteW-1:0]         mag;
    logic signed [CoordW-1:0] prod;
    logic signed [CoordW-1:0] shifted;
    delta = coord - centre[ByteW-1:0];
    mag = delta[ByteW-1] ? -delta : delta;
    prod = mag * scale;
    if (delta[ByteW-1]) begin
      prod = -prod;
    end
    shifted = prod >>> ScaleSh;
    return centre + shifted;
  endfunction

  task automatic close_polyline();
    lists_left = lists_left - 1'b1;
    phase = (lists_left == 0) ? PH_LIST : PH_POINT;
  endtask

  task automatic take_byte(input logic [ByteW-1:0] b);
    logic [CoordW-1:0] y;
    case (phase)
      PH_LIST: begin
        lists_left = b;
        phase = (b == 0) ? PH_LIST : PH_POINT;
      end
      PH_POINT: begin
        points_left = b;
        have_last = 1'b0;
        if (b == 0) begin
          close_polyline();
        end else begin
          phase = PH_X;
        end
      end
      PH_X: begin
        held_x = scale_about_centre(b, regs.x_scale, regs.center_x);
        phase = PH_Y;
      end
      default: begin
        y = scale_about_centre(b, regs.y_scale, regs.center_y);
        if (have_last && regs.fade_pattern != FadeOff) begin
          segs_due.push_back('{draw_inverse: regs.inverse_mode, dot_mask: regs.fade_pattern,
                               end_y: y, end_x: held_x, start_y: last_y, start_x: last_x});
        end
        last_x = held_x;
        last_y = y;
        have_last = 1'b1;
        points_left = points_left - 1'b1;
        if (points_left == 0) begin
          close_polyline();
        end else begin
          phase = PH_X;
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [CoordW-1:0] got,
                                 input logic [CoordW-1:0] want);
    $display("%0t ns segment %0d %s: got %h, want %h", $realtime, seg_no, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    seg_t got;
    seg_t want;
    if (rst) begin
      regs = '0;
      phase = PH_LIST;
      lists_left = '0;
      points_left = '0;
      held_x = '0;
      last_x = '0;
      last_y = '0;
      have_last = 1'b0;
      segs_due.delete();
      seg_no = 0;
      leftovers_done = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = seg_t'(m_tdata[SegW-1:0]);
        if (segs_due.size() == 0) begin
          report_mismatch("not expected, start_x", got.start_x, '0);
        end else begin
          want = segs_due.pop_front();
          if (got.start_x !== want.start_x)
            report_mismatch("start_x", got.start_x, want.start_x);
          if (got.start_y !== want.start_y)
            report_mismatch("start_y", got.start_y, want.start_y);
          if (got.end_x !== want.end_x)
            report_mismatch("end_x", got.end_x, want.end_x);
          if (got.end_y !== want.end_y)
            report_mismatch("end_y", got.end_y, want.end_y);
          if (got.dot_mask !== want.dot_mask)
            report_mismatch("dot_mask", CoordW'(got.dot_mask), CoordW'(want.dot_mask));
          if (got.draw_inverse !== want.draw_inverse)
            report_mismatch("draw_inverse", CoordW'(got.draw_inverse),
                            CoordW'(want.draw_inverse));
          if (m_tdata[OutDataW-1:SegW] !== '0)
            report_mismatch("padding", CoordW'(m_tdata[OutDataW-1:SegW]), '0);
        end
        seg_no++;
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_X_SCALE:  regs.x_scale = cfg_data[ByteW-1:0];
          REG_Y_SCALE:  regs.y_scale = cfg_data[ByteW-1:0];
          REG_CENTER_X: regs.center_x = cfg_data[CoordW-1:0];
          REG_CENTER_Y: regs.center_y = cfg_data[CoordW-1:0];
          REG_FADE:     regs.fade_pattern = cfg_data[ByteW-1:0];
          REG_INVERSE:  regs.inverse_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        take_byte(s_tdata);
      end
      if (run_done && !leftovers_done) begin
        leftovers_done = 1'b1;
        foreach (segs_due[i]) begin
          report_mismatch("never delivered, start_x", 'x, segs_due[i].start_x);
        end
      end
    end
    segs_pending <= segs_due.size();
  end

endmodule

### sim/vector_list_scaler_tb.sv
`timescale 1ns / 1ps

module vector_list_scaler_tb;
  import vls_pkg::*;

  localparam int unsigned ItemTarget  = 1150;
  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned DrainCycles = 6;
  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;

  // first byte in the lowest bits
  localparam int unsigned OpenLen = 13;
  localparam logic [8*OpenLen-1:0] Opening = {
    8'h80, 8'h80, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'd3,  // three points
    8'h7F, 8'h80, 8'd1,                              // single point
    8'd0,                                            // empty polyline
    8'd3,                                            // three polylines
    8'd0                                             // empty list
  };
  localparam int unsigned FadedLen = 6;
  localparam logic [8*FadedLen-1:0] Faded = {8'h40, 8'h30, 8'h20, 8'h10, 8'd2, 8'd1};

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                run_done;
  int unsigned         segs_pending;
  int unsigned         fail_count;
  int unsigned         bytes_sent;
  int unsigned         quiet_cycles;
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;

  vector_list_scaler i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vls_segment_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .run_done     (run_done),
    .segs_pending (segs_pending),
    .fail_count   (fail_count)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_seq(input logic [8*OpenLen-1:0] seq, input int unsigned len);
    for (int i = 0; i < len; i++) begin
      send_byte(seq[8*i +: 8]);
    end
  endtask

  // well-formed list with random coordinates
  task automatic send_list();
    int unsigned lists;
    int unsigned pts;
    lists = ($urandom_range(9) == 0) ? 0 :
            ($urandom_range(24) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    send_byte(8'(lists));
    repeat (lists) begin
      pts = ($urandom_range(7) == 0) ? $urandom_range(1) :
            ($urandom_range(29) == 0) ? $urandom_range(7, 40) : $urandom_range(2, 6);
      send_byte(8'(pts));
      repeat (2 * pts) send_byte(8'($urandom));
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (segs_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // junk in the unused upper bits; the block must mask them
  task automatic apply_settings(input cfg_t s);
    cfg_we <= 1'b1;
    put_reg(REG_X_SCALE, {8'($urandom), s.x_scale});
    put_reg(REG_Y_SCALE, {8'($urandom), s.y_scale});
    put_reg(REG_CENTER_X, s.center_x);
    put_reg(REG_CENTER_Y, s.center_y);
    put_reg(REG_FADE, {8'($urandom), s.fade_pattern});
    put_reg(REG_INVERSE, {15'($urandom), s.inverse_mode});
    put_reg(RegSpare, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] skewed_byte();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] skewed_centre();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cfg_t pick_settings(input int unsigned n);
    cfg_t s;
    if (n == 0) begin
      s = '{x_scale: 8'hFF, y_scale: 8'hFF, center_x: 16'h7FFF, center_y: 16'h8000,
            fade_pattern: 8'hFE, inverse_mode: 1'b1};
    end else if (n == 1) begin
      s = '{x_scale: 8'h00, y_scale: 8'h00, center_x: 16'h8000, center_y: 16'h7FFF,
            fade_pattern: 8'h00, inverse_mode: 1'b0};
    end else begin
      s.x_scale = skewed_byte();
      s.y_scale = skewed_byte();
      s.center_x = skewed_centre();
      s.center_y = skewed_centre();
      case ($urandom_range(4))
        0: s.fade_pattern = FadeOff;
        1: s.fade_pattern = 8'h00;
        default: s.fade_pattern = 8'($urandom);
      endcase
      s.inverse_mode = 1'($urandom);
    end
    return s;
  endfunction

  initial begin
    int unsigned phase_no;
    int unsigned phase_end;
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    run_done = 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 46;
    bytes_sent = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    apply_settings('{x_scale: 8'd128, y_scale: 8'hFF, center_x: 16'h8000, center_y: 16'h7FFF,
                     fade_pattern: 8'h00, inverse_mode: 1'b1});
    send_seq(Opening, OpenLen);
    settle();
    // fade off: parsed, nothing out
    apply_settings('{x_scale: 8'hFF, y_scale: 8'h00, center_x: 16'h00FF, center_y: 16'hFF00,
                     fade_pattern: FadeOff, inverse_mode: 1'b0});
    send_seq((8*OpenLen)'(Faded), FadedLen);

    phase_no = 0;
    while (bytes_sent < ItemTarget) begin
      settle();
      apply_settings(pick_settings(phase_no));
      phase_end = bytes_sent + $urandom_range(40, 140);
      while (bytes_sent < phase_end && bytes_sent < ItemTarget) begin
        if (bytes_sent < ItemTarget / 3) begin
          send_idle_pct <= 32;
          recv_idle_pct <= 46;
        end else if (bytes_sent < 2 * ItemTarget / 3) begin
          send_idle_pct <= 46;
          recv_idle_pct <= 32;
        end else begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
        end else begin
          send_list();
        end
      end
      phase_no++;
    end
    settle();
    run_done <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
